/* rtl/mse_pkg.sv */
// Shared types, opcodes and constants for the instruction execute block.
package mse_pkg;

   localparam int DataWordsDefault = 1024;

   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_J       = 6'd2;
   localparam logic [5:0] OP_JAL     = 6'd3;
   localparam logic [5:0] OP_BEQ     = 6'd4;
   localparam logic [5:0] OP_BNE     = 6'd5;
   localparam logic [5:0] OP_BLEZ    = 6'd6;
   localparam logic [5:0] OP_BGTZ    = 6'd7;
   localparam logic [5:0] OP_ADDI    = 6'd8;
   localparam logic [5:0] OP_LUI     = 6'd15;
   localparam logic [5:0] OP_LW      = 6'd35;
   localparam logic [5:0] OP_SW      = 6'd43;

   localparam logic [5:0] FN_SLL  = 6'd0;
   localparam logic [5:0] FN_SRL  = 6'd2;
   localparam logic [5:0] FN_JR   = 6'd8;
   localparam logic [5:0] FN_MFHI = 6'd16;
   localparam logic [5:0] FN_MFLO = 6'd18;
   localparam logic [5:0] FN_MULT = 6'd24;
   localparam logic [5:0] FN_DIV  = 6'd26;
   localparam logic [5:0] FN_ADD  = 6'd32;
   localparam logic [5:0] FN_SUB  = 6'd34;
   localparam logic [5:0] FN_AND  = 6'd36;
   localparam logic [5:0] FN_OR   = 6'd37;
   localparam logic [5:0] FN_XOR  = 6'd38;
   localparam logic [5:0] FN_SLT  = 6'd42;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_DIVZERO = 2'd2;
   localparam logic [1:0] ST_RANGE   = 2'd3;

   localparam logic [4:0] RA_INDEX = 5'd31;

   typedef enum logic [4:0] {
      K_SLL, K_SRL, K_ROTR, K_JR, K_MFHI, K_MFLO, K_MULT, K_DIV,
      K_ADD, K_SUB, K_AND, K_OR, K_XOR, K_SLT, K_J, K_JAL,
      K_BEQ, K_BNE, K_BLEZ, K_BGTZ, K_ADDI, K_LUI, K_LW, K_SW, K_BAD
   } kind_type;

   // classified instruction handed from front to back
   typedef struct packed {
      kind_type    kind;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  rd;
      logic [4:0]  sa;
      logic [25:0] target;
      logic [31:0] simm;
      logic [15:0] imm;
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_EXEC, S_MUL2, S_MUL3, S_MUL4,
      S_DIVRUN, S_DIVFIX, S_MEMRD, S_MEMWAIT, S_DONE
   } state_type;

endpackage

/* rtl/mse_ram.sv */
// Generic single-port RAM with registered read.
module mse_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

/* rtl/mse_decode.sv */
// Front end: accepts instruction words and classifies them.
module mse_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [31:0]          req_instruction,
   output logic                 op_valid,
   input  logic                 op_ready,
   output mse_pkg::op_type      op_word
);
   import mse_pkg::*;

   logic        valid_ff, valid_in;
   op_type      word_ff, word_in;
   kind_type    kind;
   logic [5:0]  opc, fn;

   assign opc = req_instruction[31:26];
   assign fn  = req_instruction[5:0];

   always_comb begin
      kind = K_BAD;
      if (opc == OP_SPECIAL) begin
         unique case (fn)
            FN_SLL:  kind = K_SLL;
            FN_SRL:  kind = (req_instruction[25:21] == 5'd1) ? K_ROTR : K_SRL;
            FN_JR:   kind = K_JR;
            FN_MFHI: kind = K_MFHI;
            FN_MFLO: kind = K_MFLO;
            FN_MULT: kind = K_MULT;
            FN_DIV:  kind = K_DIV;
            FN_ADD:  kind = K_ADD;
            FN_SUB:  kind = K_SUB;
            FN_AND:  kind = K_AND;
            FN_OR:   kind = K_OR;
            FN_XOR:  kind = K_XOR;
            FN_SLT:  kind = K_SLT;
            default: kind = K_BAD;
         endcase
      end else begin
         unique case (opc)
            OP_J:    kind = K_J;
            OP_JAL:  kind = K_JAL;
            OP_BEQ:  kind = K_BEQ;
            OP_BNE:  kind = K_BNE;
            OP_BLEZ: kind = K_BLEZ;
            OP_BGTZ: kind = K_BGTZ;
            OP_ADDI: kind = K_ADDI;
            OP_LUI:  kind = K_LUI;
            OP_LW:   kind = K_LW;
            OP_SW:   kind = K_SW;
            default: kind = K_BAD;
         endcase
      end
   end

   // single-entry queue towards the back end
   assign req_ready = !valid_ff || op_ready;
   assign op_valid  = valid_ff;
   assign op_word   = word_ff;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (op_ready) begin
         valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         valid_in       = 1'b1;
         word_in.kind   = kind;
         word_in.rs     = req_instruction[25:21];
         word_in.rt     = req_instruction[20:16];
         word_in.rd     = req_instruction[15:11];
         word_in.sa     = req_instruction[10:6];
         word_in.target = req_instruction[25:0];
         word_in.imm    = req_instruction[15:0];
         word_in.simm   = {{16{req_instruction[15]}}, req_instruction[15:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (op_valid && !op_ready) |=> (op_valid && $stable(op_word)))
      else $error("queued word changed while stalled");
endmodule

/* rtl/mse_divider.sv */
// Iterative signed divider, one quotient bit per cycle.
module mse_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   import mse_pkg::*;

   logic        busy_ff, busy_in;
   logic [5:0]  count_ff, count_in;
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic        qneg_ff, qneg_in, rneg_ff, rneg_in, done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] shifted;

   assign shifted = {rem_ff[30:0], quo_ff[31]};
   assign trial   = {1'b0, shifted} - {1'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      qneg_in  = qneg_ff;
      rneg_in  = rneg_ff;
      done_in  = 1'b0;
      if (start) begin
         busy_in  = 1'b1;
         count_in = 6'd0;
         rem_in   = 32'd0;
         quo_in   = dividend[31] ? 32'd0 - dividend : dividend;
         dvs_in   = divisor[31] ? 32'd0 - divisor : divisor;
         qneg_in  = dividend[31] ^ divisor[31];
         rneg_in  = dividend[31];
      end else if (busy_ff) begin
         if (rem_ff[31] || !trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      qneg_ff  <= qneg_in;
      rneg_ff  <= rneg_in;
   end

   assign done      = done_ff;
   assign quotient  = qneg_ff ? 32'd0 - quo_ff : quo_ff;
   assign remainder = rneg_ff ? 32'd0 - rem_ff : rem_ff;

   assert property (@(posedge clock) disable iff (reset) done |-> !busy_ff)
      else $error("divider done while still busy");
endmodule

/* rtl/mse_execute.sv */
// Back end: register file, hi/lo, pc, multiply, divide and data memory.
module mse_execute #(
   parameter int DataWords = mse_pkg::DataWordsDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            op_valid,
   output logic            op_ready,
   input  mse_pkg::op_type op_word,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [31:0]     rsp_next_pc,
   output logic            rsp_reg_written,
   output logic [4:0]      rsp_reg_index,
   output logic [31:0]     rsp_reg_value,
   output logic            rsp_mem_written,
   output logic [9:0]      rsp_mem_address,
   output logic [31:0]     rsp_mem_value,
   output logic [1:0]      rsp_status
);
   import mse_pkg::*;

   localparam int AW = $clog2(DataWords);

   state_type   state_ff, state_in;
   op_type      cur_ff, cur_in;
   logic [31:0] gpr_ff [32];
   logic [31:0] a_ff, a_in, b_ff, b_in;
   logic [31:0] hi_ff, hi_in, lo_ff, lo_in, pc_ff, pc_in;
   logic [31:0] p_ll_ff, p_lh_ff, p_hl_ff, p_hh_ff;
   logic [63:0] prod_ff;
   logic        mneg_ff;
   logic [31:0] ma_ff, mb_ff;
   logic        vld_ff, vld_in;
   logic [31:0] npc_ff, npc_in, rv_ff, rv_in, mv_ff, mv_in;
   logic        rw_ff, rw_in, mw_ff, mw_in;
   logic [4:0]  ri_ff, ri_in;
   logic [9:0]  mad_ff, mad_in;
   logic [1:0]  st_ff, st_in;
   logic        gw;
   logic [4:0]  gidx;
   logic [31:0] gval;
   logic        div_start, div_done;
   logic [31:0] div_q, div_r;
   logic        ram_we;
   logic [31:0] ram_q, addr_sum;
   logic [AW-1:0] ram_addr;
   logic [31:0] sh_r, sh_l, sh_rot;
   logic [4:0]  sa;
   logic        in_range;
   logic        take;

   assign sa       = cur_ff.sa;
   assign sh_r     = b_ff >> sa;
   assign sh_l     = b_ff << sa;
   assign sh_rot   = (sa == 5'd0) ? b_ff : (sh_r | (b_ff << (6'd32 - {1'b0, sa})));
   assign addr_sum = a_ff + cur_ff.simm;
   assign in_range = addr_sum < 32'(DataWords);
   assign ram_addr = addr_sum[AW-1:0];

   // a new word is taken only once the result register is free by this edge
   assign take = (state_ff == S_IDLE) && op_valid && (!vld_ff || rsp_ready);

   mse_divider u_div (
      .clock, .reset, .start(div_start), .dividend(a_ff), .divisor(b_ff),
      .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   mse_ram #(.Width(32), .Depth(DataWords)) u_dmem (
      .clock, .wr_en(ram_we), .addr(ram_addr), .wr_data(b_ff), .rd_data(ram_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (take) state_in = S_READ;
         S_READ:    state_in = S_EXEC;
         S_EXEC: begin
            if (cur_ff.kind == K_MULT) state_in = S_MUL2;
            else if (cur_ff.kind == K_DIV && b_ff != 32'd0) state_in = S_DIVRUN;
            else if (cur_ff.kind == K_LW && in_range) state_in = S_MEMRD;
            else state_in = S_DONE;
         end
         S_MUL2:    state_in = S_MUL3;
         S_MUL3:    state_in = S_MUL4;
         S_MUL4:    state_in = S_DONE;
         S_DIVRUN:  if (div_done) state_in = S_DIVFIX;
         S_DIVFIX:  state_in = S_DONE;
         S_MEMRD:   state_in = S_MEMWAIT;
         S_MEMWAIT: state_in = S_DONE;
         S_DONE:    if (!vld_ff || rsp_ready) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      op_ready  = (state_ff == S_IDLE) && (!vld_ff || rsp_ready);
      cur_in    = cur_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      pc_in     = pc_ff;
      npc_in    = npc_ff;
      rw_in     = rw_ff;
      ri_in     = ri_ff;
      rv_in     = rv_ff;
      mw_in     = mw_ff;
      mad_in    = mad_ff;
      mv_in     = mv_ff;
      st_in     = st_ff;
      vld_in    = vld_ff && !rsp_ready;
      gw        = 1'b0;
      gidx      = ri_ff;
      gval      = rv_ff;
      div_start = 1'b0;
      ram_we    = 1'b0;
      unique case (state_ff)
         S_IDLE: if (take) cur_in = op_word;
         S_READ: begin
            a_in = gpr_ff[cur_ff.rs];
            b_in = gpr_ff[cur_ff.rt];
         end
         S_EXEC: begin
            npc_in = pc_ff + 32'd4;
            rw_in  = 1'b0;
            ri_in  = cur_ff.rd;
            rv_in  = 32'd0;
            mw_in  = 1'b0;
            mad_in = 10'd0;
            mv_in  = 32'd0;
            st_in  = ST_OK;
            case (cur_ff.kind)
               K_SLL:  begin rw_in = 1'b1; rv_in = sh_l; end
               K_SRL:  begin rw_in = 1'b1; rv_in = sh_r; end
               K_ROTR: begin rw_in = 1'b1; rv_in = sh_rot; end
               K_JR:   npc_in = a_ff;
               K_MFHI: begin rw_in = 1'b1; rv_in = hi_ff; end
               K_MFLO: begin rw_in = 1'b1; rv_in = lo_ff; end
               K_ADD:  begin rw_in = 1'b1; rv_in = a_ff + b_ff; end
               K_SUB:  begin rw_in = 1'b1; rv_in = a_ff - b_ff; end
               K_AND:  begin rw_in = 1'b1; rv_in = a_ff & b_ff; end
               K_OR:   begin rw_in = 1'b1; rv_in = a_ff | b_ff; end
               K_XOR:  begin rw_in = 1'b1; rv_in = a_ff ^ b_ff; end
               K_SLT:  begin
                  rw_in = 1'b1;
                  rv_in = {31'd0, $signed(a_ff) < $signed(b_ff)};
               end
               K_J:    npc_in = {4'd0, cur_ff.target, 2'b00};
               K_JAL:  begin
                  npc_in = {4'd0, cur_ff.target, 2'b00};
                  rw_in  = 1'b1; ri_in = RA_INDEX; rv_in = pc_ff + 32'd8;
               end
               K_BEQ:  if (a_ff == b_ff) npc_in = pc_ff + {cur_ff.simm[29:0], 2'b00};
               K_BNE:  if (a_ff != b_ff) npc_in = pc_ff + {cur_ff.simm[29:0], 2'b00};
               K_BLEZ: if ($signed(a_ff) <= 0) npc_in = pc_ff + {cur_ff.simm[29:0], 2'b00};
               K_BGTZ: if ($signed(a_ff) > 0) npc_in = pc_ff + {cur_ff.simm[29:0], 2'b00};
               K_ADDI: begin rw_in = 1'b1; ri_in = cur_ff.rt; rv_in = a_ff + cur_ff.simm; end
               K_LUI:  begin rw_in = 1'b1; ri_in = cur_ff.rt; rv_in = {cur_ff.imm, 16'd0}; end
               K_LW:   begin
                  ri_in = cur_ff.rt;
                  if (in_range) mad_in = 10'(addr_sum);
                  else st_in = ST_RANGE;
               end
               K_SW:   begin
                  if (in_range) begin
                     ram_we = 1'b1; mw_in = 1'b1;
                     mad_in = 10'(addr_sum); mv_in = b_ff;
                  end else begin
                     st_in = ST_RANGE;
                  end
               end
               K_DIV:  if (b_ff == 32'd0) st_in = ST_DIVZERO; else div_start = 1'b1;
               K_MULT: ;
               default: st_in = ST_UNKNOWN;
            endcase
            pc_in = npc_in;
         end
         S_MUL2: ;
         S_MUL3: ;
         S_MUL4: begin
            hi_in = prod_ff[63:32];
            lo_in = prod_ff[31:0];
         end
         S_DIVRUN: ;
         S_DIVFIX: begin
            hi_in = div_r;
            lo_in = div_q;
         end
         S_MEMRD: ;
         S_MEMWAIT: begin
            rw_in = 1'b1; rv_in = ram_q; mv_in = ram_q;
         end
         S_DONE: begin
            if (!vld_ff || rsp_ready) begin
               if (rw_ff && ri_ff != 5'd0) begin
                  gw = 1'b1;
               end else begin
                  rw_in = 1'b0; ri_in = 5'd0; rv_in = 32'd0;
               end
               if (!(rw_ff && ri_ff != 5'd0)) begin
                  rw_in = 1'b0;
               end
               vld_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // multiply on magnitudes as four 16x16 partials
   always_ff @(posedge clock) begin
      if (state_ff == S_EXEC) begin
         ma_ff   <= a_ff[31] ? 32'd0 - a_ff : a_ff;
         mb_ff   <= b_ff[31] ? 32'd0 - b_ff : b_ff;
         mneg_ff <= a_ff[31] ^ b_ff[31];
      end
      p_ll_ff <= ma_ff[15:0] * mb_ff[15:0];
      p_lh_ff <= ma_ff[15:0] * mb_ff[31:16];
      p_hl_ff <= ma_ff[31:16] * mb_ff[15:0];
      p_hh_ff <= ma_ff[31:16] * mb_ff[31:16];
   end

   logic [63:0] mag;
   assign mag = {p_hh_ff, p_ll_ff} + {16'd0, p_lh_ff, 16'd0} + {16'd0, p_hl_ff, 16'd0};

   always_ff @(posedge clock) begin
      prod_ff <= mneg_ff ? 64'd0 - mag : mag;
   end

   // magnitudes load at the EXEC edge, partials at MUL2, the signed sum at MUL3,
   // so prod is ready to copy into hi/lo in MUL4

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
         hi_ff    <= 32'd0;
         lo_ff    <= 32'd0;
         pc_ff    <= 32'd0;
         for (int i = 0; i < 32; i++) gpr_ff[i] <= 32'd0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
         pc_ff    <= pc_in;
         if (gw) gpr_ff[gidx] <= gval;
      end
      cur_ff <= cur_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      npc_ff <= npc_in;
      rw_ff  <= rw_in;
      ri_ff  <= ri_in;
      rv_ff  <= rv_in;
      mw_ff  <= mw_in;
      mad_ff <= mad_in;
      mv_ff  <= mv_in;
      st_ff  <= st_in;
   end

   assign rsp_valid       = vld_ff;
   assign rsp_next_pc     = npc_ff;
   assign rsp_reg_written = rw_ff;
   assign rsp_reg_index   = ri_ff;
   assign rsp_reg_value   = rv_ff;
   assign rsp_mem_written = mw_ff;
   assign rsp_mem_address = mad_ff;
   assign rsp_mem_value   = mv_ff;
   assign rsp_status      = st_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reg_written) |-> (rsp_reg_index != 5'd0))
      else $error("register zero reported as written");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (!rsp_reg_written && !rsp_mem_written))
      else $error("faulting word has side effects");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !op_ready)
      else $error("back end took a word while busy");
endmodule

/* rtl/mips_subset_execute.sv */
// Top level: MIPS subset executor, decode front end and execute back end.
//
//   channel | ports                  | direction | word
//   req     | req_valid/ready        | in        | instruction
//   rsp     | rsp_valid/ready        | out       | next_pc, reg/mem effects, status
//
// The back end steps through take, register read, execute and retire for a simple
// instruction; lw adds a memory read and wait, mult the multiply states MUL2 to MUL4,
// and div the iterative divide (32 quotient bits) and a fix-up. A result word is valid
// the cycle after retire. The front end queues one decoded word, so a new instruction is
// taken while the back end works. The back end takes no new word while a result
// word waits for rsp_ready.
// Reset clears registers, hi, lo and pc; data memory is undefined until written.
module mips_subset_execute #(
   parameter int DataWords = mse_pkg::DataWordsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instruction,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_reg_index,
   output logic [31:0] rsp_reg_value,
   output logic        rsp_mem_written,
   output logic [9:0]  rsp_mem_address,
   output logic [31:0] rsp_mem_value,
   output logic [1:0]  rsp_status
);
   import mse_pkg::*;

   logic   op_valid, op_ready;
   op_type op_word;

   mse_decode u_front (
      .clock, .reset, .req_valid, .req_ready, .req_instruction,
      .op_valid, .op_ready, .op_word
   );

   mse_execute #(.DataWords(DataWords)) u_back (
      .clock, .reset, .op_valid, .op_ready, .op_word,
      .rsp_valid, .rsp_ready, .rsp_next_pc, .rsp_reg_written, .rsp_reg_index,
      .rsp_reg_value, .rsp_mem_written, .rsp_mem_address, .rsp_mem_value, .rsp_status
   );
endmodule

/* test/tb_top.sv */
// Testbench for mips_subset_execute: random and directed instruction streams, checked per word.
`timescale 1ns / 100ps

module tb_top;
   import mse_pkg::*;

   localparam int MemWords  = 1024;
   localparam int CycleLimit = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_instruction;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_next_pc;
   logic        rsp_reg_written;
   logic [4:0]  rsp_reg_index;
   logic [31:0] rsp_reg_value;
   logic        rsp_mem_written;
   logic [9:0]  rsp_mem_address;
   logic [31:0] rsp_mem_value;
   logic [1:0]  rsp_status;

   // one expected outcome of an instruction
   typedef struct packed {
      logic [31:0] next_pc;
      logic        reg_written;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        mem_written;
      logic [9:0]  mem_address;
      logic [31:0] mem_value;
      logic [1:0]  status;
   } outcome_t;

   mips_subset_execute uut (.*);

   // shadow architectural state
   logic [31:0] shadow_gpr [32];
   logic [31:0] shadow_hi, shadow_lo, shadow_pc;
   logic [31:0] shadow_mem [MemWords];
   bit          mem_stored [MemWords];

   logic [31:0] instr_queue [$];
   outcome_t    outcome_queue [$];
   int          error_count;
   int          words_checked;
   int          cycle_count;
   int          send_idle_pct;
   int          recv_stall_pct;
   bit          stim_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Execute one instruction against the shadow state and return the outcome.
   function automatic outcome_t execute_instr(logic [31:0] ins);
      outcome_t         o;
      logic [5:0]       op, fn;
      logic [4:0]       rs, rt, rd, sa;
      logic [31:0]      simm, a, b, here, addr;
      logic signed [63:0] prod, x, y;
      op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16];
      rd = ins[15:11]; sa = ins[10:6];  fn = ins[5:0];
      simm = {{16{ins[15]}}, ins[15:0]};
      a = shadow_gpr[rs]; b = shadow_gpr[rt];
      here = shadow_pc;
      o = '0;
      o.next_pc = here + 32'd4;
      o.status = ST_OK;
      if (op == OP_SPECIAL) begin
         o.reg_written = 1'b1;
         o.reg_index = rd;
         case (fn)
            FN_SLL: o.reg_value = b << sa;
            FN_SRL: begin
               if (rs == 5'd1) o.reg_value = (b >> sa) | (b << (6'd32 - sa));
               else o.reg_value = b >> sa;
            end
            FN_JR: begin
               o.reg_written = 1'b0;
               o.next_pc = a;
            end
            FN_MFHI: o.reg_value = shadow_hi;
            FN_MFLO: o.reg_value = shadow_lo;
            FN_MULT: begin
               prod = $signed(a) * $signed(b);
               {shadow_hi, shadow_lo} = prod;
               o.reg_written = 1'b0;
            end
            FN_DIV: begin
               o.reg_written = 1'b0;
               if (b == 0) o.status = ST_DIVZERO;
               else begin
                  x = $signed(a);
                  y = $signed(b);
                  shadow_lo = 32'(x / y);
                  shadow_hi = 32'(x % y);
               end
            end
            FN_ADD: o.reg_value = a + b;
            FN_SUB: o.reg_value = a - b;
            FN_AND: o.reg_value = a & b;
            FN_OR:  o.reg_value = a | b;
            FN_XOR: o.reg_value = a ^ b;
            FN_SLT: o.reg_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            default: begin
               o.reg_written = 1'b0;
               o.status = ST_UNKNOWN;
            end
         endcase
      end else begin
         case (op)
            OP_J: o.next_pc = {4'd0, ins[25:0], 2'b00};
            OP_JAL: begin
               o.reg_written = 1'b1;
               o.reg_index = RA_INDEX;
               o.reg_value = here + 32'd8;
               o.next_pc = {4'd0, ins[25:0], 2'b00};
            end
            OP_BEQ:  if (a == b) o.next_pc = here + (simm << 2);
            OP_BNE:  if (a != b) o.next_pc = here + (simm << 2);
            OP_BLEZ: if ($signed(a) <= 0) o.next_pc = here + (simm << 2);
            OP_BGTZ: if ($signed(a) > 0) o.next_pc = here + (simm << 2);
            OP_ADDI: begin
               o.reg_written = 1'b1; o.reg_index = rt; o.reg_value = a + simm;
            end
            OP_LUI: begin
               o.reg_written = 1'b1; o.reg_index = rt; o.reg_value = {ins[15:0], 16'd0};
            end
            OP_LW, OP_SW: begin
               addr = a + simm;
               if (addr >= MemWords) o.status = ST_RANGE;
               else begin
                  o.mem_address = addr[9:0];
                  if (op == OP_LW) begin
                     o.mem_value = shadow_mem[addr];
                     o.reg_written = 1'b1; o.reg_index = rt; o.reg_value = o.mem_value;
                  end else begin
                     o.mem_value = b;
                     shadow_mem[addr] = b;
                     mem_stored[addr] = 1'b1;
                     o.mem_written = 1'b1;
                  end
               end
            end
            default: o.status = ST_UNKNOWN;
         endcase
      end
      if (o.reg_written && o.reg_index == 0) o.reg_written = 1'b0;
      if (o.reg_written) shadow_gpr[o.reg_index] = o.reg_value;
      else begin
         o.reg_index = '0;
         o.reg_value = '0;
      end
      shadow_pc = o.next_pc;
      return o;
   endfunction

   // A load from a word never stored is illegal; swap it for a safe store.
   function automatic logic [31:0] make_legal(logic [31:0] ins);
      logic [31:0] addr;
      addr = shadow_gpr[ins[25:21]] + {{16{ins[15]}}, ins[15:0]};
      if (ins[31:26] == OP_LW && addr < MemWords && !mem_stored[addr])
         return {OP_SW, ins[25:0]};
      return ins;
   endfunction

   // Queue an instruction and its expected outcome.
   task automatic issue(logic [31:0] ins);
      logic [31:0] legal;
      legal = make_legal(ins);
      instr_queue.push_back(legal);
      outcome_queue.push_back(execute_instr(legal));
   endtask

   function automatic logic [31:0] rtype(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [4:0] sa, logic [5:0] fn);
      return {OP_SPECIAL, rs, rt, rd, sa, fn};
   endfunction

   function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   // Mostly meaningful instructions with random fields; some pure noise.
   function automatic logic [31:0] random_instr();
      logic [4:0]  rs, rt, rd, sa;
      logic [15:0] imm;
      logic [5:0]  fns [13];
      logic [5:0]  ops [10];
      int          pick;
      fns = '{FN_SLL, FN_SRL, FN_JR, FN_MFHI, FN_MFLO, FN_MULT, FN_DIV,
              FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_SLT};
      ops = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_LUI, OP_LW, OP_SW};
      rs = $urandom; rt = $urandom; rd = $urandom; sa = $urandom; imm = $urandom;
      pick = $urandom_range(99);
      if (pick < 8) return $urandom;
      if (pick < 20) begin
         // memory access near base of data memory
         if ($urandom_range(3) == 0) rs = 5'd0;
         imm = (pick < 18) ? 16'($urandom_range(MemWords + 20)) : imm;
         return itype(($urandom_range(1) != 0) ? OP_LW : OP_SW, rs, rt, imm);
      end
      if (pick < 30) begin
         if ($urandom_range(1) != 0) rs = 5'd1;
         return rtype(rs, rt, rd, sa, FN_SRL);
      end
      if (pick < 70) return rtype(rs, rt, rd, sa, fns[$urandom_range(12)]);
      return itype(ops[$urandom_range(9)], rs, rt, imm);
   endfunction

   initial begin
      logic [5:0] fn_all [13];
      fn_all = '{FN_SLL, FN_SRL, FN_JR, FN_MFHI, FN_MFLO, FN_MULT, FN_DIV,
                 FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_SLT};
      for (int i = 0; i < 32; i++) shadow_gpr[i] = '0;
      for (int i = 0; i < MemWords; i++) begin
         shadow_mem[i] = '0;
         mem_stored[i] = 1'b0;
      end
      shadow_hi = '0; shadow_lo = '0; shadow_pc = '0;
      error_count = 0; words_checked = 0; cycle_count = 0;
      send_idle_pct = 0; recv_stall_pct = 0; stim_done = 1'b0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every op, and the special cases
      issue(itype(OP_LUI, 5'd0, 5'd1, 16'h8000));        // r1 = 0x80000000
      issue(itype(OP_ADDI, 5'd0, 5'd2, 16'hFFFF));       // r2 = -1
      issue(itype(OP_ADDI, 5'd0, 5'd0, 16'h1234));       // write to r0 dropped
      issue(rtype(5'd1, 5'd2, 5'd0, 5'd0, FN_DIV));      // overflow divide
      issue(rtype(5'd0, 5'd0, 5'd3, 5'd0, FN_MFHI));
      issue(rtype(5'd0, 5'd0, 5'd4, 5'd0, FN_MFLO));
      issue(rtype(5'd1, 5'd0, 5'd0, 5'd0, FN_DIV));      // divide by zero
      issue(rtype(5'd1, 5'd1, 5'd0, 5'd0, FN_MULT));     // full 64-bit product
      issue(rtype(5'd0, 5'd0, 5'd5, 5'd0, FN_MFHI));
      issue(rtype(5'd1, 5'd2, 5'd6, 5'd31, FN_SRL));     // rotr, max shift
      issue(rtype(5'd0, 5'd1, 5'd7, 5'd31, FN_SRL));     // logical srl
      issue(rtype(5'd1, 5'd1, 5'd8, 5'd0, FN_SRL));      // rotr by zero
      issue(rtype(5'd0, 5'd2, 5'd9, 5'd31, FN_SLL));
      for (int i = 7; i < 13; i++) issue(rtype(5'd1, 5'd2, 5'd10, 5'd0, fn_all[i]));
      issue(itype(OP_SW, 5'd0, 5'd1, 16'd1023));          // last word
      issue(itype(OP_LW, 5'd0, 5'd11, 16'd1023));
      issue(itype(OP_SW, 5'd0, 5'd1, 16'd1024));          // out of range
      issue(itype(OP_LW, 5'd2, 5'd12, 16'd0));            // wraps to huge address
      issue(rtype(5'd0, 5'd0, 5'd0, 5'd0, 6'd63));        // unknown function
      issue({6'd63, 26'h3FFFFFF});                        // unknown opcode
      issue({OP_JAL, 26'h3FFFFFF});
      issue(itype(OP_BLEZ, 5'd1, 5'd0, 16'h8000));
      issue(itype(OP_BGTZ, 5'd1, 5'd0, 16'h7FFF));
      issue(itype(OP_BEQ, 5'd0, 5'd0, 16'hFFFF));
      issue(itype(OP_BNE, 5'd1, 5'd0, 16'h0001));
      issue(rtype(5'd31, 5'd0, 5'd0, 5'd0, FN_JR));
      issue({OP_J, 26'h0});

      // random phases: free-running, idle sender, stalling receiver, both
      for (int phase = 0; phase < 4; phase++) begin
         wait (instr_queue.size() == 0);
         send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 35 : 61) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 35 : 61) : 0;
         for (int i = 0; i < 200; i++) issue(random_instr());
      end
      wait (instr_queue.size() == 0);
      stim_done = 1'b1;
   end

   // Driver: presents queued words; holds each until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) void'(instr_queue.pop_front());
         if (instr_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_instruction <= instr_queue[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch word %0d %s: got %h expected %h", words_checked, what, got, want);
      error_count++;
   endtask

   // Monitor: compares each accepted result word with the oldest expectation.
   always @(posedge clock) begin
      outcome_t want;
      cycle_count <= cycle_count + 1;
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (outcome_queue.size() == 0) begin
            report_mismatch("unexpected word", rsp_next_pc, '0);
         end else begin
            want = outcome_queue.pop_front();
            if (rsp_next_pc !== want.next_pc)
               report_mismatch("next_pc", rsp_next_pc, want.next_pc);
            if (rsp_reg_written !== want.reg_written)
               report_mismatch("reg_written", 32'(rsp_reg_written), 32'(want.reg_written));
            if (rsp_reg_index !== want.reg_index)
               report_mismatch("reg_index", 32'(rsp_reg_index), 32'(want.reg_index));
            if (rsp_reg_value !== want.reg_value)
               report_mismatch("reg_value", rsp_reg_value, want.reg_value);
            if (rsp_mem_written !== want.mem_written)
               report_mismatch("mem_written", 32'(rsp_mem_written), 32'(want.mem_written));
            if (rsp_mem_address !== want.mem_address)
               report_mismatch("mem_address", 32'(rsp_mem_address), 32'(want.mem_address));
            if (rsp_mem_value !== want.mem_value)
               report_mismatch("mem_value", rsp_mem_value, want.mem_value);
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
         end
         words_checked++;
      end
   end

   // End of run, or timeout.
   initial begin
      wait (stim_done && outcome_queue.size() == 0);
      repeat (100) @(posedge clock);
      $display("checked %0d result words over four handshake phases", words_checked);
      $display("mismatches counted: %0d", error_count);
      if (error_count == 0 && outcome_queue.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      wait (cycle_count >= CycleLimit);
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
   end

endmodule
